/* hw/rtl/thc_pkg.sv */
// thc_pkg: shared types, register indexes and constants of the
// temperature / humidity compensation pipeline. No dependencies.
package thc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_TEMP_COEFF_ONE      = 3'd0;
	localparam logic [2:0] REG_TEMP_COEFF_TWO      = 3'd1;
	localparam logic [2:0] REG_TEMP_COEFF_THREE    = 3'd2;
	localparam logic [2:0] REG_HUM_COEFF_ONE       = 3'd3;
	localparam logic [2:0] REG_HUM_COEFF_TWO       = 3'd4;
	localparam logic [2:0] REG_HUM_COEFF_THREE     = 3'd5;
	localparam logic [2:0] REG_HUM_COEFF_FOUR_FIVE = 3'd6;
	localparam logic [2:0] REG_HUM_COEFF_SIX       = 3'd7;

	localparam logic [31:0] FINE_OFFSET   = 32'd76800;
	localparam logic [31:0] P1_ROUND      = 32'd16384;
	localparam logic [31:0] R_BIAS        = 32'd32768;
	localparam logic [31:0] S_BIAS        = 32'd2097152;
	localparam logic [31:0] P2_ROUND      = 32'd8192;
	localparam logic [31:0] HUM_CLAMP_MAX = 32'd419430400;
	localparam logic [31:0] TEMP_ROUND    = 32'd128;
	localparam logic [16:0] HUM_Q10_MAX   = 17'd102400;

	typedef struct packed {
		logic [15:0] temp_coeff_one;
		logic [15:0] temp_coeff_two;
		logic [15:0] temp_coeff_three;
		logic [7:0]  hum_coeff_one;
		logic [15:0] hum_coeff_two;
		logic [7:0]  hum_coeff_three;
		logic [23:0] hum_coeff_four_five;
		logic [7:0]  hum_coeff_six;
	} cal_t;

	typedef struct packed {
		logic adv;   // whole pipeline advances this cycle
		logic vld;   // valid bit entering the first stage of the module
	} pipe_ctl_t;

	// arithmetic right shift of a 32-bit two's complement word
	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
		logic signed [31:0] sx;
		sx = $signed(x);
		return 32'(sx >>> sh);
	endfunction

endpackage

/* hw/rtl/thc_temp_pipe.sv */
// thc_temp_pipe: four-stage fine temperature datapath.
// Depends on thc_pkg (cal_t, pipe_ctl_t, asr32).
module thc_temp_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  thc_pkg::pipe_ctl_t ctl,
	input  thc_pkg::cal_t     cal,
	input  logic [19:0]       temp_adc,
	input  logic [15:0]       raw_hum,
	output logic              vld_s4,
	output logic [31:0]       fine_s4,
	output logic [15:0]       hum_s4
);
	import thc_pkg::*;

	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] a0_s1, d_s1;
	logic [31:0] pa_s2, pd_s2;
	logic [31:0] a_s3, pb_s3;
	logic [15:0] hum_s1, hum_s2, hum_s3;
	logic [31:0] t1, t2, t3;

	assign t1 = {16'b0, cal.temp_coeff_one};
	assign t2 = {{16{cal.temp_coeff_two[15]}}, cal.temp_coeff_two};
	assign t3 = {{16{cal.temp_coeff_three[15]}}, cal.temp_coeff_three};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			a0_s1   <= {15'b0, temp_adc[19:3]} - {t1[30:0], 1'b0};
			d_s1    <= {16'b0, temp_adc[19:4]} - t1;
			hum_s1  <= raw_hum;
			pa_s2   <= a0_s1 * t2;
			pd_s2   <= d_s1 * d_s1;
			hum_s2  <= hum_s1;
			a_s3    <= asr32(pa_s2, 11);
			pb_s3   <= asr32(pd_s2, 12) * t3;
			hum_s3  <= hum_s2;
			fine_s4 <= a_s3 + asr32(pb_s3, 14);
			hum_s4  <= hum_s3;
		end
	end

endmodule

/* hw/rtl/thc_hum_pipe.sv */
// thc_hum_pipe: ten-stage humidity datapath plus the hundredths scaling.
// Depends on thc_pkg (cal_t, pipe_ctl_t, asr32, constants).
module thc_hum_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  thc_pkg::pipe_ctl_t ctl,
	input  thc_pkg::cal_t      cal,
	input  logic [31:0]        fine_in,
	input  logic [15:0]        hum_in,
	output logic               vld_s14,
	output logic [31:0]        fine_s14,
	output logic [23:0]        temp_s14,
	output logic [16:0]        hum_s14
);
	import thc_pkg::*;

	logic [13:5] vld;
	logic [31:0] fine_s5, fine_s6, fine_s7, fine_s8, fine_s9, fine_s10,
	             fine_s11, fine_s12, fine_s13;
	logic [23:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10,
	             temp_s11, temp_s12, temp_s13;
	logic [31:0] x_s5;
	logic [15:0] adch_s5, adch_s6;
	logic [31:0] m5_s6, mq_s6, mr_s6;
	logic [31:0] p1_s7, q_s7, r_s7;
	logic [31:0] p1_s8, ms_s8;
	logic [31:0] p1_s9, ps2_s9;
	logic [31:0] p1_s10, p2_s10;
	logic [31:0] v_s11, v_s12, v_s13;
	logic [31:0] sq_s12, c0_s13;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic [31:0] t5, s_val, v15, vv, vclamp;

	assign h1 = {24'b0, cal.hum_coeff_one};
	assign h2 = {{16{cal.hum_coeff_two[15]}}, cal.hum_coeff_two};
	assign h3 = {24'b0, cal.hum_coeff_three};
	assign h4 = {{20{cal.hum_coeff_four_five[23]}}, cal.hum_coeff_four_five[23:12]};
	assign h5 = {{20{cal.hum_coeff_four_five[11]}}, cal.hum_coeff_four_five[11:0]};
	assign h6 = {{24{cal.hum_coeff_six[7]}}, cal.hum_coeff_six};

	assign t5    = {fine_in[29:0], 2'b0} + fine_in + TEMP_ROUND;
	assign s_val = asr32(ms_s8, 10) + S_BIAS;
	assign v15   = asr32(v_s11, 15);
	assign vv    = v_s13 - asr32(c0_s13, 4);

	always_comb begin
		priority if (vv[31])
			vclamp = '0;
		else if (vv > HUM_CLAMP_MAX)
			vclamp = HUM_CLAMP_MAX;
		else
			vclamp = vv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld     <= '0;
			vld_s14 <= 1'b0;
		end else if (ctl.adv) begin
			vld     <= {vld[12:5], ctl.vld};
			vld_s14 <= vld[13];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			// s5: offset fine temperature, hundredths
			x_s5    <= fine_in - FINE_OFFSET;
			temp_s5 <= 24'(asr32(t5, 8));
			fine_s5 <= fine_in;
			adch_s5 <= hum_in;
			// s6: products with x
			m5_s6   <= h5 * x_s5;
			mq_s6   <= x_s5 * h6;
			mr_s6   <= x_s5 * h3;
			adch_s6 <= adch_s5;
			// s7
			p1_s7 <= asr32({2'b0, adch_s6, 14'b0} - {h4[11:0], 20'b0} - m5_s6 + P1_ROUND, 15);
			q_s7  <= asr32(mq_s6, 10);
			r_s7  <= asr32(mr_s6, 11) + R_BIAS;
			// s8
			ms_s8 <= q_s7 * r_s7;
			p1_s8 <= p1_s7;
			// s9
			ps2_s9 <= s_val * h2;
			p1_s9  <= p1_s8;
			// s10
			p2_s10 <= asr32(ps2_s9 + P2_ROUND, 14);
			p1_s10 <= p1_s9;
			// s11
			v_s11 <= p1_s10 * p2_s10;
			// s12
			sq_s12 <= v15 * v15;
			v_s12  <= v_s11;
			// s13
			c0_s13 <= asr32(sq_s12, 7) * h1;
			v_s13  <= v_s12;
			// s14: correction, clamp, Q7.10 result
			hum_s14 <= vclamp[28:12];
			// carry temperature results alongside
			fine_s6  <= fine_s5;  temp_s6  <= temp_s5;
			fine_s7  <= fine_s6;  temp_s7  <= temp_s6;
			fine_s8  <= fine_s7;  temp_s8  <= temp_s7;
			fine_s9  <= fine_s8;  temp_s9  <= temp_s8;
			fine_s10 <= fine_s9;  temp_s10 <= temp_s9;
			fine_s11 <= fine_s10; temp_s11 <= temp_s10;
			fine_s12 <= fine_s11; temp_s12 <= temp_s11;
			fine_s13 <= fine_s12; temp_s13 <= temp_s12;
			fine_s14 <= fine_s13; temp_s14 <= temp_s13;
		end
	end

endmodule

/* hw/rtl/temp_humidity_compensation.sv */
// temp_humidity_compensation: top level, calibration registers and
// pipeline flow control. Depends on thc_pkg, thc_temp_pipe, thc_hum_pipe.
//
// channel   signals                                  direction
// -------   --------------------------------------   ---------
// input     in_valid/in_ready, temp_adc, raw_hum     sink
// output    out_valid/out_ready, fine_temp,          source
//           temp_hundredths, humidity_q10
// config    cfg_we, cfg_index, cfg_data              sink, no handshake
//
// One transaction per cycle, sustained while the output is not stalled.
// An accepted transaction passes through 14 register stages (4 for fine
// temperature, 10 for humidity). The depth is set by the chain of eight
// dependent 32-bit multiplies, one register after each.
// Reset clears every stage valid bit and the calibration registers to zero.
// When out_valid is high and out_ready is low, hold every stage; in_ready
// drops in that same cycle, so nothing is lost or repeated.
module temp_humidity_compensation (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] temp_adc,
	input  logic [15:0] raw_hum,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] fine_temp,
	output logic [23:0] temp_hundredths,
	output logic [16:0] humidity_q10,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import thc_pkg::*;

	cal_t        cal_q;
	pipe_ctl_t   temp_ctl, hum_ctl;
	logic        adv;
	logic        tv_s4;
	logic [31:0] fine_s4;
	logic [15:0] hum_s4;

	// Advance the whole pipeline unless the output register is full and blocked.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	assign temp_ctl = '{adv: adv, vld: in_valid};
	assign hum_ctl  = '{adv: adv, vld: tv_s4};

	// Calibration registers: drop bits above each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_COEFF_ONE:      cal_q.temp_coeff_one      <= cfg_data[15:0];
				REG_TEMP_COEFF_TWO:      cal_q.temp_coeff_two      <= cfg_data[15:0];
				REG_TEMP_COEFF_THREE:    cal_q.temp_coeff_three    <= cfg_data[15:0];
				REG_HUM_COEFF_ONE:       cal_q.hum_coeff_one       <= cfg_data[7:0];
				REG_HUM_COEFF_TWO:       cal_q.hum_coeff_two       <= cfg_data[15:0];
				REG_HUM_COEFF_THREE:     cal_q.hum_coeff_three     <= cfg_data[7:0];
				REG_HUM_COEFF_FOUR_FIVE: cal_q.hum_coeff_four_five <= cfg_data;
				REG_HUM_COEFF_SIX:       cal_q.hum_coeff_six       <= cfg_data[7:0];
			endcase
		end
	end

	// Fine temperature: stages 1 to 4.
	thc_temp_pipe u_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (temp_ctl),
		.cal      (cal_q),
		.temp_adc (temp_adc),
		.raw_hum  (raw_hum),
		.vld_s4   (tv_s4),
		.fine_s4  (fine_s4),
		.hum_s4   (hum_s4)
	);

	// Humidity and hundredths: stages 5 to 14; stage 14 is the output register.
	thc_hum_pipe u_hum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hum_ctl),
		.cal      (cal_q),
		.fine_in  (fine_s4),
		.hum_in   (hum_s4),
		.vld_s14  (out_valid),
		.fine_s14 (fine_temp),
		.temp_s14 (temp_hundredths),
		.hum_s14  (humidity_q10)
	);

`ifndef SYNTHESIS
	// Clamp must keep humidity within 0..100 percent.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity_q10 <= HUM_Q10_MAX))
		else $error("humidity_q10 above clamp limit");

	// A blocked output must freeze the inner stages too.
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ($stable(tv_s4) && $stable(fine_s4) && $stable(hum_s4)))
		else $error("inner pipeline moved during stall");

	// An empty output register never blocks the input.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");
`endif

endmodule
